### sv/rrts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin time-slice scheduler package
// Widths, codes and shared types for the scheduler top level and its queue
// cells.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int MAX_PROCS = 16;
  localparam int ID_BITS   = 8;
  localparam int PID_W     = 8;
  localparam int TIME_W    = 16;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [PID_W-1:0]   pid_t;
  typedef logic [TIME_W-1:0]  tval_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam tval_t SLICE_RESET = tval_t'(3);

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_SERVE = 1'b1
  } op_e;

  // Contents of one queue cell.
  typedef struct packed {
    id_t   id;
    tval_t remain;
  } cell_data_t;

  // Per-cell control: shift takes the neighbor's entry, load takes the
  // broadcast entry. Load wins over shift.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

### sv/rrts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler queue cell
// Holds one waiting process and moves it one place toward the head on a pop.
// ----------------------------------------------------------------------------
module rrts_cell (
  input  logic                   clk_i,
  input  rrts_pkg::cell_ctrl_t   ctrl_i,
  input  rrts_pkg::cell_data_t   next_i,
  input  rrts_pkg::cell_data_t   load_i,
  output rrts_pkg::cell_data_t   data_o
);

  rrts_pkg::cell_data_t data_q;
  rrts_pkg::cell_data_t data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = load_i;
    end else if (ctrl_i.shift) begin
      data_d = next_i;
    end
  end

  // Entry contents carry no reset; the fill count says which cells matter.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### sv/round_robin_time_slice_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin time-slice scheduler
// Bounded queue of processes served in turn with a fixed time slice.
// ----------------------------------------------------------------------------
// Each request is either an add, which appends a process at the tail of the
// queue (or is rejected when all MAX_PROCS places are taken), or a serve,
// which grants the head process one slice: it completes and leaves when its
// remaining time is at most the slice, and otherwise rejoins at the tail with
// the slice subtracted. A serve on an empty queue reports idle. Every request
// gives exactly one result. The queue is a row of cells with the head in cell
// zero; a pop shifts every cell one place toward the head in the same cycle,
// while a single entry (new or rejoining) is written at the tail position
// given by the fill count. The result of a request appears in the output
// register on the next cycle, and a new request is accepted in every cycle in
// which that register is empty or being taken. After reset the queue is empty
// and the slice is 3. The slice register is written through its own
// valid/ready channel, which is always ready, and should only be written while
// no request is in flight.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [7:0]            proc_tag_i,
  input  logic [15:0]           run_time_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            served_id_o,
  output logic [15:0]           time_left_o,
  output logic                  completed_o,
  output logic                  idle_o,
  output logic                  rejected_o,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [15:0]           cfg_data_i
);

  localparam int N = rrts_pkg::MAX_PROCS;

  // Queue cells and their control.
  rrts_pkg::cell_data_t cell_data [N];
  rrts_pkg::cell_data_t cell_next [N];
  rrts_pkg::cell_ctrl_t cell_ctrl [N];
  rrts_pkg::cell_data_t load_data;

  rrts_pkg::cnt_t  count_q, count_d;
  rrts_pkg::tval_t slice_q;

  logic out_valid_q, out_valid_d;
  rrts_pkg::pid_t  out_id_q, out_id_d;
  rrts_pkg::tval_t out_time_q, out_time_d;
  logic out_done_q, out_done_d;
  logic out_idle_q, out_idle_d;
  logic out_rej_q, out_rej_d;

  logic            accept;
  rrts_pkg::op_e   op;
  logic            full;
  logic            empty;
  logic            fits;
  rrts_pkg::tval_t remain_new;
  logic            do_load;
  logic            do_shift;
  rrts_pkg::cnt_t  load_idx;

  assign accept = in_valid_i && in_ready_o;
  assign op     = rrts_pkg::op_e'(operation_i);
  assign full   = (count_q == rrts_pkg::cnt_t'(N));
  assign empty  = (count_q == '0);

  // The head always sits in cell zero.
  assign fits       = (cell_data[0].remain <= slice_q);
  assign remain_new = cell_data[0].remain - slice_q;

  // Request decode: one tail write and/or one pop per accepted request.
  always_comb begin
    do_load   = 1'b0;
    do_shift  = 1'b0;
    load_idx  = count_q;
    load_data = '{id: rrts_pkg::id_t'(proc_tag_i), remain: run_time_i};
    count_d   = count_q;
    unique case (op)
      rrts_pkg::OP_ADD: begin
        if (accept && !full) begin
          do_load = 1'b1;
          count_d = count_q + rrts_pkg::cnt_t'(1);
        end
      end
      rrts_pkg::OP_SERVE: begin
        // After the pop the tail slot is one place nearer the head.
        load_idx  = count_q - rrts_pkg::cnt_t'(1);
        load_data = '{id: cell_data[0].id, remain: remain_new};
        if (accept && !empty) begin
          do_shift = 1'b1;
          if (fits) begin
            count_d = count_q - rrts_pkg::cnt_t'(1);
          end else begin
            do_load = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Result of the request.
  always_comb begin
    out_id_d   = '0;
    out_time_d = '0;
    out_done_d = 1'b0;
    out_idle_d = 1'b0;
    out_rej_d  = 1'b0;
    unique case (op)
      rrts_pkg::OP_ADD: begin
        if (full) begin
          out_rej_d = 1'b1;
          out_id_d  = proc_tag_i;
        end else begin
          out_id_d   = rrts_pkg::pid_t'(rrts_pkg::id_t'(proc_tag_i));
          out_time_d = run_time_i;
        end
      end
      rrts_pkg::OP_SERVE: begin
        if (empty) begin
          out_idle_d = 1'b1;
        end else begin
          out_id_d = rrts_pkg::pid_t'(cell_data[0].id);
          if (fits) begin
            out_done_d = 1'b1;
          end else begin
            out_time_d = remain_new;
          end
        end
      end
      default: ;
    endcase
  end

  // The row of cells; the last cell has no neighbor and shifts in don't-care
  // data, which lies beyond the fill count.
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_last
      assign cell_next[i] = load_data;
    end else begin : g_mid
      assign cell_next[i] = cell_data[i+1];
    end

    assign cell_ctrl[i].shift = do_shift;
    assign cell_ctrl[i].load  = do_load && (load_idx == rrts_pkg::cnt_t'(i));

    rrts_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[i]),
      .next_i (cell_next[i]),
      .load_i (load_data),
      .data_o (cell_data[i])
    );
  end

  // Output register: holds the result until it is taken.
  assign in_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      slice_q     <= rrts_pkg::SLICE_RESET;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        slice_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_id_q   <= out_id_d;
      out_time_q <= out_time_d;
      out_done_q <= out_done_d;
      out_idle_q <= out_idle_d;
      out_rej_q  <= out_rej_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  assign out_valid_o = out_valid_q;
  assign served_id_o = out_id_q;
  assign time_left_o = out_time_q;
  assign completed_o = out_done_q;
  assign idle_o      = out_idle_q;
  assign rejected_o  = out_rej_q;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin time-slice scheduler testbench
// Self-checking bench that sends add and serve requests, predicts every
// result with its own model of the process ring, and checks each field.
// ----------------------------------------------------------------------------
// The bench starts with a short directed sequence. It serves an empty ring,
// adds processes with extreme identifiers and times, and serves them so that
// they complete at and below the slice and rejoin above it. It then fills the
// ring and offers one more add, which must be rejected. After that it runs
// random phases under several slice lengths: the reset value, one, the
// largest value, zero, and random values. Each phase mixes adds and serves so
// that the ring fills up and drains again. Random gaps on the request side and
// random stalls on the result side are switched on and off per phase. The
// slice register is only written once every owed result has been taken.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QUIET_LIMIT = 5000;

  // One result as the scheduler reports it.
  typedef struct packed {
    rrts_pkg::id_t   sid;
    rrts_pkg::tval_t left;
    logic            completed;
    logic            idle;
    logic            rejected;
  } sched_result_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid    = 1'b0;
  rrts_pkg::op_e   operation   = rrts_pkg::OP_ADD;
  rrts_pkg::pid_t  proc_tag    = '0;
  rrts_pkg::tval_t run_time    = '0;
  logic            out_ready   = 1'b0;
  logic            cfg_valid   = 1'b0;
  rrts_pkg::tval_t cfg_data    = '0;

  logic  in_ready_o;
  logic  out_valid_o;
  logic  [7:0]  served_id_o;
  logic  [15:0] time_left_o;
  logic  completed_o;
  logic  idle_o;
  logic  rejected_o;
  logic  cfg_ready_o;

  // Model of the process ring and the slice register.
  rrts_pkg::id_t   ring_id   [rrts_pkg::MAX_PROCS];
  rrts_pkg::tval_t ring_time [rrts_pkg::MAX_PROCS];
  int              ring_head = 0;
  int              ring_tail = 0;
  int              ring_fill = 0;
  rrts_pkg::tval_t slice_now = rrts_pkg::SLICE_RESET;

  // Results owed by the scheduler, oldest first.
  sched_result_t owed_grants[$];

  int errors       = 0;
  int n_adds       = 0;
  int n_rejects    = 0;
  int n_idles      = 0;
  int n_completes  = 0;
  int n_rejoins    = 0;
  int n_slices     = 1;
  int quiet_cycles = 0;
  int stall_left   = 0;
  bit gaps_on      = 1'b0;
  bit stalls_on    = 1'b0;

  round_robin_time_slice_scheduler_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation),
    .proc_tag_i   (proc_tag),
    .run_time_i   (run_time),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .served_id_o  (served_id_o),
    .time_left_o  (time_left_o),
    .completed_o  (completed_o),
    .idle_o       (idle_o),
    .rejected_o   (rejected_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Gap length in cycles: mostly none or short, now and then a long one.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Applies one request to the ring model and returns the result it owes.
  function automatic sched_result_t schedule_request(rrts_pkg::op_e op,
                                                     rrts_pkg::id_t pid,
                                                     rrts_pkg::tval_t et);
    sched_result_t r;
    rrts_pkg::tval_t t;
    r = '0;
    if (op == rrts_pkg::OP_ADD) begin
      if (ring_fill == rrts_pkg::MAX_PROCS) begin
        r.rejected = 1'b1;
        r.sid = pid;
        n_rejects++;
      end else begin
        ring_id[ring_tail] = pid;
        ring_time[ring_tail] = et;
        ring_tail = (ring_tail + 1) % rrts_pkg::MAX_PROCS;
        ring_fill++;
        r.sid = pid;
        r.left = et;
        n_adds++;
      end
    end else if (ring_fill == 0) begin
      r.idle = 1'b1;
      n_idles++;
    end else begin
      t = ring_time[ring_head];
      r.sid = ring_id[ring_head];
      ring_head = (ring_head + 1) % rrts_pkg::MAX_PROCS;
      if (t <= slice_now) begin
        // The process finishes within its turn and leaves the ring.
        r.completed = 1'b1;
        ring_fill--;
        n_completes++;
      end else begin
        // Not done yet: charge one slice and send it to the back.
        r.left = t - slice_now;
        ring_id[ring_tail] = r.sid;
        ring_time[ring_tail] = r.left;
        ring_tail = (ring_tail + 1) % rrts_pkg::MAX_PROCS;
        n_rejoins++;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  // Sends one request. Valid is left high on return so that a following
  // request can go out back to back; anything else lowers it first.
  task automatic send_request(rrts_pkg::op_e op, rrts_pkg::pid_t pid,
                              rrts_pkg::tval_t et);
    int gap;
    gap = gaps_on ? next_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    proc_tag  <= pid;
    run_time  <= et;
    do @(posedge clk_i); while (!in_ready_o);
    owed_grants.push_back(schedule_request(op, pid, et));
  endtask

  // Holds the request side until every owed result has been taken.
  task automatic drain_grants();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (owed_grants.size() != 0);
  endtask

  // Changes the slice length once the scheduler has gone quiet.
  task automatic write_slice(rrts_pkg::tval_t value);
    drain_grants();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    slice_now = value;
    n_slices++;
  endtask

  // Execution times are mostly a few slices long so that processes both
  // complete and rejoin; the rest are zero or spread over the whole range.
  function automatic rrts_pkg::tval_t pick_run_time();
    int r;
    int bound;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return rrts_pkg::tval_t'($urandom_range(0, 65535));
    if (r < 20) return 16'hFFFF;
    bound = 4 * int'(slice_now) + 2;
    if (bound > 65535) bound = 65535;
    return rrts_pkg::tval_t'($urandom_range(0, bound));
  endfunction

  // Serve on an empty ring, then extreme identifiers and times. With the
  // reset slice of three, a zero time and a time equal to the slice both
  // complete, while the largest time and a time just above the slice rejoin.
  task automatic test_edges();
    send_request(rrts_pkg::OP_SERVE, 8'hFF, 16'hFFFF);
    send_request(rrts_pkg::OP_ADD, 8'h00, 16'h0000);
    send_request(rrts_pkg::OP_ADD, 8'hFF, 16'hFFFF);
    send_request(rrts_pkg::OP_ADD, 8'hA5, 16'h0003);
    send_request(rrts_pkg::OP_ADD, 8'h5A, 16'h0004);
    repeat (4) send_request(rrts_pkg::OP_SERVE, 8'h00, 16'h0000);
  endtask

  // Fills every place in the ring, then one more add must be rejected and
  // report its own identifier.
  task automatic test_full_ring();
    while (ring_fill < rrts_pkg::MAX_PROCS)
      send_request(rrts_pkg::OP_ADD, rrts_pkg::pid_t'($urandom_range(0, 255)),
                   pick_run_time());
    send_request(rrts_pkg::OP_ADD, 8'hC3, 16'h1234);
  endtask

  // Random adds and serves. The add share changes every few dozen requests
  // so that the ring swings between full and empty.
  task automatic test_random_traffic(int count);
    int add_pct;
    rrts_pkg::op_e op;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) add_pct = ($urandom_range(0, 2) == 0) ? 25 :
                                 ($urandom_range(0, 1) == 0) ? 50 : 75;
      op = ($urandom_range(0, 99) < add_pct) ? rrts_pkg::OP_ADD : rrts_pkg::OP_SERVE;
      send_request(op, rrts_pkg::pid_t'($urandom_range(0, 255)), pick_run_time());
      if (gaps_on && $urandom_range(0, 99) == 0) drain_grants();
    end
  endtask

  // Result side: random stalls while enabled, otherwise always ready.
  always @(posedge clk_i) begin
    if (stalls_on && stall_left == 0) stall_left = next_gap();
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compares every accepted result with the oldest owed one.
  always @(posedge clk_i) begin : check_results
    sched_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (owed_grants.size() == 0) begin
        $display("%0t: result with nothing owed, id %0h time %0h", $time,
                 served_id_o, time_left_o);
        errors++;
      end else begin
        want = owed_grants.pop_front();
        check_field("served_id", 16'(want.sid), 16'(served_id_o));
        check_field("time_left", want.left, time_left_o);
        check_field("completed", 16'(want.completed), 16'(completed_o));
        check_field("idle", 16'(want.idle), 16'(idle_o));
        check_field("rejected", 16'(want.rejected), 16'(rejected_o));
      end
    end
  end

  // Counts cycles in which no channel moves anything.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t: no progress for %0d cycles, %0d results still owed", $time,
             QUIET_LIMIT, owed_grants.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_edges();
    test_full_ring();

    // Reset slice of three, never written so far.
    test_random_traffic(250);
    write_slice(16'd1);
    test_random_traffic(250);
    write_slice(16'hFFFF);
    test_random_traffic(150);
    // Zero slice: processes with time left go round without being charged.
    write_slice(16'd0);
    test_random_traffic(150);
    write_slice(rrts_pkg::tval_t'($urandom_range(2, 20)));
    test_random_traffic(300);
    write_slice(rrts_pkg::tval_t'($urandom_range(1, 65535)));
    test_random_traffic(150);
    // Back to back on both sides.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_slice(16'd3);
    test_random_traffic(200);

    drain_grants();
    repeat (4) @(posedge clk_i);
    $display("Covered %0d adds, %0d rejected adds, %0d idle serves,", n_adds, n_rejects,
             n_idles);
    $display("%0d completions and %0d rejoins over %0d slice settings.", n_completes,
             n_rejoins, n_slices);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### round_robin_time_slice_scheduler_top.f
sv/rrts_pkg.sv
sv/rrts_cell.sv
sv/round_robin_time_slice_scheduler_top.sv
test/tb_top.sv
